FILE: rtl/totp_pkg.sv
`default_nettype none
package totp_pkg;

   localparam int STEP_SECONDS_DEF = 30;
   localparam int CODE_MOD = 1000000;

   // floor(bin / CODE_MOD) = (bin * CODE_MOD_RECIP) >> CODE_MOD_SHIFT, low by at most one
   localparam int CODE_MOD_SHIFT = 51;
   localparam logic [31:0] CODE_MOD_RECIP = 32'((64'd1 << CODE_MOD_SHIFT) / 64'(CODE_MOD));

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;

   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   typedef struct packed {
      logic [63:0] unix_seconds;
      logic [19:0] candidate_code;
   } req_type;

   typedef struct packed {
      logic        code_valid;
      logic [19:0] expected_code;
   } rsp_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/totp_code_validator.sv
`default_nettype none
// TOTP (RFC 6238, HMAC-SHA1) code checker. One request at a time: the time step counter is
// found by long division in four 16-bit digits, each by reciprocal multiplication on one
// shared 32x32 multiplier with a single correction, then four SHA-1 compressions run on one
// shared round unit, one round per cycle plus a load state and a digest-add state each, then
// the truncated value is reduced modulo 1000000 by reciprocal multiplication on the same
// multiplier, and the S_OUT state moves the result into the output register. Once the result
// is there the block returns to idle and the next request can be taken. While a result waits
// in the output register the next request is worked on; it stalls only when it is finished
// and the output register is still full. The key is to be written through the csr port
// while idle; the block itself does not enforce this.
module totp_code_validator #(
   parameter int STEP_SECONDS = totp_pkg::STEP_SECONDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire totp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output totp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [63:0]       csr_data
);

   localparam logic [31:0] STEP = (STEP_SECONDS < 1) ? 32'd1 : 32'(STEP_SECONDS);
   // floor(x / STEP) = (x * DIV_M) >> 32, low by at most one for x below STEP * 2^16
   localparam logic [31:0] DIV_M = 32'(32'hFFFF_FFFF / STEP);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_RND  = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_MOD  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]   state_ff, state_in;
   logic [63:0]  key_high_ff;
   logic [15:0]  key_low_ff;
   logic [19:0]  cand_ff;
   logic [63:0]  quo_ff, quo_in;
   logic [15:0]  rem_ff, rem_in;
   logic [15:0]  qd_ff, qd_in;
   logic [1:0]   ph_ff, ph_in;
   logic [63:0]  prod_ff, prod_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [1:0]   blk_ff, blk_in;
   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff, a_in, b_in, c_in, d_in, e_in;
   logic [159:0] h_ff, h_in, inner_ff, inner_in;
   logic [31:0]  mv_ff, mv_in;
   logic [19:0]  code_ff, code_in;
   logic         rsp_valid_ff, rsp_valid_in;
   totp_pkg::rsp_type rsp_ff, rsp_in;

   logic [511:0] key_blk, blk_msg;
   logic [31:0]  wt, wnew, tmp;
   logic [3:0]   off;
   logic [31:0]  bin;
   logic [159:0] hsum;
   logic [31:0]  mul_a, mul_b;
   logic [31:0]  div_x, div_r, mod_r;
   logic [15:0]  q_dig;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      key_blk = {key_high_ff, key_low_ff, 432'd0};
      unique case (blk_ff)
         2'd0: blk_msg = key_blk ^ {64{totp_pkg::IPAD}};
         2'd1: blk_msg = {quo_ff, 8'h80, 376'd0, 64'd576};
         2'd2: blk_msg = key_blk ^ {64{totp_pkg::OPAD}};
         default: blk_msg = {inner_ff, 8'h80, 280'd0, 64'd672};
      endcase
   end

   assign wt = w_ff[0];
   assign wnew = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
                 | {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} >> 31;
   assign tmp = {a_ff[26:0], a_ff[31:27]} + totp_pkg::round_f(cnt_ff, b_ff, c_ff, d_ff)
                + e_ff + totp_pkg::round_k(cnt_ff) + wt;
   assign hsum = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                  h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
   assign off = hsum[3:0];
   assign bin = 32'(hsum[159 - 8*off -: 32]) & 32'h7FFFFFFF;

   assign div_x = {rem_ff, quo_ff[63:48]};
   assign div_r = div_x - prod_ff[31:0];
   assign mod_r = mv_ff - prod_ff[31:0];
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      state_in = state_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff; blk_in = blk_ff;
      qd_in = qd_ff; ph_in = ph_ff; q_dig = qd_ff;
      mul_a = div_x; mul_b = DIV_M;
      w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff; inner_in = inner_ff; mv_in = mv_ff; code_in = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               quo_in = req_data.unix_seconds;
               rem_in = 16'd0;
               cnt_in = 7'd0;
               ph_in = 2'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            unique case (ph_ff)
               2'd0: begin
                  mul_a = div_x;
                  mul_b = DIV_M;
                  ph_in = 2'd1;
               end
               2'd1: begin
                  mul_a = {16'd0, prod_ff[47:32]};
                  mul_b = STEP;
                  qd_in = prod_ff[47:32];
                  ph_in = 2'd2;
               end
               default: begin
                  if (div_r >= STEP) begin
                     rem_in = 16'(div_r - STEP);
                     q_dig = qd_ff + 16'd1;
                  end else begin
                     rem_in = div_r[15:0];
                     q_dig = qd_ff;
                  end
                  quo_in = {quo_ff[47:0], q_dig};
                  ph_in = 2'd0;
                  cnt_in = cnt_ff + 7'd1;
                  if (cnt_ff == 7'd3) begin
                     blk_in = 2'd0;
                     h_in = {totp_pkg::H0, totp_pkg::H1, totp_pkg::H2, totp_pkg::H3,
                             totp_pkg::H4};
                     state_in = S_LOAD;
                  end
               end
            endcase
         end
         S_LOAD: begin
            for (int i = 0; i < 16; i++) w_in[i] = blk_msg[511 - 32*i -: 32];
            a_in = h_ff[159:128]; b_in = h_ff[127:96]; c_in = h_ff[95:64];
            d_in = h_ff[63:32]; e_in = h_ff[31:0];
            cnt_in = 7'd0;
            state_in = S_RND;
         end
         S_RND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = wnew;
            e_in = d_ff; d_in = c_ff; c_in = {b_ff[1:0], b_ff[31:2]}; b_in = a_ff; a_in = tmp;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd79) state_in = S_ADD;
         end
         S_ADD: begin
            h_in = hsum;
            blk_in = blk_ff + 2'd1;
            state_in = S_LOAD;
            if (blk_ff == 2'd1) begin
               inner_in = hsum;
               h_in = {totp_pkg::H0, totp_pkg::H1, totp_pkg::H2, totp_pkg::H3, totp_pkg::H4};
            end else if (blk_ff == 2'd3) begin
               mv_in = bin;
               ph_in = 2'd0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            unique case (ph_ff)
               2'd0: begin
                  mul_a = mv_ff;
                  mul_b = totp_pkg::CODE_MOD_RECIP;
                  ph_in = 2'd1;
               end
               2'd1: begin
                  mul_a = 32'(prod_ff >> totp_pkg::CODE_MOD_SHIFT);
                  mul_b = 32'(totp_pkg::CODE_MOD);
                  ph_in = 2'd2;
               end
               default: begin
                  if (mod_r >= 32'(totp_pkg::CODE_MOD))
                     code_in = 20'(mod_r - 32'(totp_pkg::CODE_MOD));
                  else
                     code_in = mod_r[19:0];
                  ph_in = 2'd0;
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.code_valid = (code_ff == cand_ff);
               rsp_in.expected_code = code_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         key_high_ff <= 64'd0;
         key_low_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               totp_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
               totp_pkg::CSR_KEY_LOW:  key_low_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) cand_ff <= req_data.candidate_code;
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in; blk_ff <= blk_in;
      qd_ff <= qd_in; ph_ff <= ph_in; prod_ff <= prod_in;
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      h_ff <= h_in; inner_ff <= inner_in; mv_ff <= mv_in; code_ff <= code_in;
      rsp_ff <= rsp_in;
   end

   a_rsp_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.expected_code < 20'(totp_pkg::CODE_MOD)))
      else $error("expected code out of range");
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DIV))
      else $error("request not started");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped");

endmodule
`default_nettype wire
